### design/skt_pkg.sv
// ============================================================================
// skt_pkg: shared types and constants for the sorted key table
// Operation and status codes used by the core and the testbench.
// ============================================================================
package skt_pkg;

    localparam int DEF_CAPACITY = 64;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_AVG    = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_DUP      = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

endpackage

### design/skt_div.sv
// ============================================================================
// skt_div: restoring serial divider
// Divides the running sum by the entry count, one quotient bit per cycle.
// ============================================================================
module skt_div
    import skt_pkg::*;
#(
    parameter int NW = 30,
    parameter int DW = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg;
    logic [DW:0]   r_reg;
    logic [DW-1:0] d_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;

    // One shift-and-subtract step.
    always_comb
    begin
        trial = {r_reg[DW-1:0], q_reg[NW-1]};
        diff  = trial - {1'b0, d_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg <= num;
            r_reg <= '0;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            if (!diff[DW])
            begin
                r_reg <= diff;
                q_reg <= {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_reg <= trial;
                q_reg <= {q_reg[NW-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

### design/sorted_key_table_core.sv
// ============================================================================
// sorted_key_table_core: ordered key/value table with running-sum average
// A sequencer walks and shifts the key/value memories one entry at a time.
// ============================================================================
// Insert and delete scan for the lower bound, then shift the entries after it;
// an average runs the serial divider over the running sum to its result.
// Throughput: one transaction at a time; in_ready is low while busy.
// The single-port memory walk and the 31-step serial divider set the rate.
// Reset clears the count, sum and sequencer; memories are not cleared.
module sorted_key_table_core
    import skt_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic signed [31:0] key,
    input  logic [23:0] value,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [23:0] average,
    output logic [6:0]  entries
);
    localparam int AW = $clog2(CAPACITY);
    localparam int NW = $clog2(CAPACITY + 1);
    localparam int SW = 24 + NW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN  = 3'd1;
    localparam logic [2:0] S_CHECK = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [31:0] kmem [CAPACITY];
    logic [23:0] vmem [CAPACITY];

    logic [2:0]    state_reg;
    logic [NW-1:0] count_reg;
    logic [SW-1:0] sum_reg;
    logic [NW-1:0] idx_reg;
    logic [NW-1:0] pos_reg;
    logic [1:0]    op_reg;
    logic [31:0]   k_reg;
    logic [23:0]   v_reg;
    logic [31:0]   rk_reg;
    logic [23:0]   rv_reg;
    logic          rd_pend_reg;
    logic [2:0]    status_reg;
    logic [23:0]   avg_reg;
    logic          shift_wr_reg;
    logic          div_start;
    logic          div_done;
    logic [SW-1:0] quo;
    logic [AW-1:0] rd_addr;
    logic          rd_en;

    // The read port serves both the scan and the shift walk.
    // Once the scan has found its entry the read data is held for the check.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (state_reg == S_SCAN && idx_reg < count_reg
            && !(rd_pend_reg && rk_reg >= k_reg))
        begin
            rd_en   = 1'b1;
            rd_addr = idx_reg[AW-1:0];
        end
        else if (state_reg == S_SHIFT && op_reg == OP_DELETE
                 && idx_reg + 1'b1 < count_reg)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg + 1'b1);
        end
        else if (state_reg == S_SHIFT && op_reg == OP_INSERT && idx_reg > pos_reg)
        begin
            rd_en   = 1'b1;
            rd_addr = AW'(idx_reg - 1'b1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rk_reg <= kmem[rd_addr];
            rv_reg <= vmem[rd_addr];
        end
    end

    skt_div #(.NW(SW), .DW(NW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (count_reg),
        .done  (div_done),
        .quo   (quo)
    );

    assign div_start = (state_reg == S_CHECK) && (op_reg == OP_AVG)
                       && (count_reg != '0);

    // Sequencer: scan for the lower bound, then shift one entry at a time, or divide for an average.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            sum_reg     <= '0;
            rd_pend_reg <= 1'b0;
            shift_wr_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg      <= op;
                        k_reg       <= key ^ 32'h8000_0000;
                        v_reg       <= value;
                        idx_reg     <= '0;
                        rd_pend_reg <= 1'b0;
                        avg_reg     <= '0;
                        status_reg  <= ST_DONE;
                        state_reg   <= (op == OP_AVG) ? S_CHECK : S_SCAN;
                        if (op == OP_UNUSED)
                            state_reg <= S_OUT;
                    end
                end
                S_SCAN:
                begin
                    // Compare the entry read last cycle with the search key.
                    if (rd_pend_reg && rk_reg >= k_reg)
                    begin
                        pos_reg   <= idx_reg - 1'b1;
                        state_reg <= S_CHECK;
                    end
                    else if (idx_reg >= count_reg)
                    begin
                        pos_reg   <= count_reg;
                        rd_pend_reg <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                    else
                    begin
                        idx_reg     <= idx_reg + 1'b1;
                        rd_pend_reg <= 1'b1;
                    end
                end
                S_CHECK:
                begin
                    state_reg <= S_OUT;
                    if (op_reg == OP_AVG)
                    begin
                        if (count_reg == '0)
                            status_reg <= ST_EMPTY;
                        else
                            state_reg <= S_DIV;
                    end
                    else if (op_reg == OP_INSERT)
                    begin
                        if (rd_pend_reg && rk_reg == k_reg)
                            status_reg <= ST_DUP;
                        else if (count_reg >= NW'(CAPACITY))
                            status_reg <= ST_FULL;
                        else
                        begin
                            idx_reg      <= count_reg;
                            shift_wr_reg <= 1'b0;
                            sum_reg      <= sum_reg + SW'(v_reg);
                            state_reg    <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                            status_reg <= ST_EMPTY;
                        else if (!(rd_pend_reg && rk_reg == k_reg))
                            status_reg <= ST_NOTFOUND;
                        else
                        begin
                            sum_reg      <= sum_reg - SW'(rv_reg);
                            idx_reg      <= pos_reg;
                            shift_wr_reg <= 1'b0;
                            state_reg    <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT:
                begin
                    // Read issued one cycle, written the next.
                    if (!shift_wr_reg)
                    begin
                        if (op_reg == OP_INSERT)
                        begin
                            if (idx_reg == pos_reg)
                            begin
                                kmem[AW'(idx_reg)] <= k_reg;
                                vmem[AW'(idx_reg)] <= v_reg;
                                count_reg <= count_reg + 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                                shift_wr_reg <= 1'b1;
                        end
                        else
                        begin
                            if (idx_reg + 1'b1 >= count_reg)
                            begin
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                                shift_wr_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        kmem[AW'(idx_reg)] <= rk_reg;
                        vmem[AW'(idx_reg)] <= rv_reg;
                        shift_wr_reg <= 1'b0;
                        if (op_reg == OP_INSERT)
                            idx_reg <= idx_reg - 1'b1;
                        else
                            idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        avg_reg   <= quo[23:0];
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign status    = status_reg;
    assign average   = avg_reg;
    assign entries   = 7'(count_reg);

    // The table never exceeds its capacity.
    a_cap: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= NW'(CAPACITY))
        else $error("entry count above capacity");

    // A finished transaction holds its result until taken.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("result dropped");

    // The count changes only from the shift state, by at most one per transaction.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_SHIFT) |=> $stable(count_reg))
        else $error("count changed outside shift");

    // The sum of an empty table is zero.
    a_sum: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 && state_reg == S_IDLE |-> sum_reg == '0)
        else $error("sum nonzero with empty table");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// Testbench for sorted_key_table_core
// Drives insert, delete and average transactions over valid/ready channels and
// checks every result against an ordered-table predictor kept in a scoreboard.
// ============================================================================

// Predicts the result of each transaction and checks the block's results.
class key_table_scoreboard;
    logic signed [31:0] keys[$];
    logic [23:0]        vals[$];
    logic [29:0]        sum;
    logic [2:0]         exp_status[$];
    logic [23:0]        exp_average[$];
    logic [6:0]         exp_entries[$];
    int                 errors;

    function void clear();
        keys.delete();
        vals.delete();
        sum = '0;
        errors = 0;
    endfunction

    // Applies one accepted transaction to the table copy and queues its result.
    function void note_request(logic [1:0] op, logic signed [31:0] key, logic [23:0] value);
        int pos;
        logic [2:0] st;
        logic [23:0] avg;
        pos = 0;
        st = skt_pkg::ST_DONE;
        avg = '0;
        while (pos < keys.size() && keys[pos] < key)
            pos++;
        if (op == skt_pkg::OP_INSERT)
        begin
            if (pos < keys.size() && keys[pos] == key)
                st = skt_pkg::ST_DUP;
            else if (keys.size() >= skt_pkg::DEF_CAPACITY)
                st = skt_pkg::ST_FULL;
            else
            begin
                keys.insert(pos, key);
                vals.insert(pos, value);
                sum += value;
            end
        end
        else if (op == skt_pkg::OP_DELETE)
        begin
            if (keys.size() == 0)
                st = skt_pkg::ST_EMPTY;
            else if (pos >= keys.size() || keys[pos] != key)
                st = skt_pkg::ST_NOTFOUND;
            else
            begin
                sum -= vals[pos];
                keys.delete(pos);
                vals.delete(pos);
            end
        end
        else if (op == skt_pkg::OP_AVG)
        begin
            if (keys.size() == 0)
                st = skt_pkg::ST_EMPTY;
            else
                avg = 24'(sum / keys.size());
        end
        exp_status.push_back(st);
        exp_average.push_back(avg);
        exp_entries.push_back(7'(keys.size()));
    endfunction

    function void check_result(logic [2:0] st, logic [23:0] avg, logic [6:0] ent);
        if (exp_status.size() == 0)
        begin
            $display("%0t: unexpected result status=%0d average=%0d entries=%0d",
                     $time, st, avg, ent);
            errors++;
            return;
        end
        if (st !== exp_status[0])
        begin
            $display("%0t: status expected %0d actual %0d", $time, exp_status[0], st);
            errors++;
        end
        if (avg !== exp_average[0])
        begin
            $display("%0t: average expected %0d actual %0d", $time, exp_average[0], avg);
            errors++;
        end
        if (ent !== exp_entries[0])
        begin
            $display("%0t: entries expected %0d actual %0d", $time, exp_entries[0], ent);
            errors++;
        end
        void'(exp_status.pop_front());
        void'(exp_average.pop_front());
        void'(exp_entries.pop_front());
    endfunction

    function int pending();
        return exp_status.size();
    endfunction
endclass

module tb
    import skt_pkg::*;
();

    localparam int CYCLE_LIMIT = 1500000;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         op;
    logic signed [31:0] key;
    logic [23:0]        value;
    logic               out_valid;
    logic               out_ready;
    logic [2:0]         status;
    logic [23:0]        average;
    logic [6:0]         entries;

    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 cycle_count;
    key_table_scoreboard board;

    sorted_key_table_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .average   (average),
        .entries   (entries)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Timeout guard.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, and each accepted transaction is checked.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(status, average, entries);
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Sends one transaction, with a random idle gap before it.
    // Valid is dropped only while idling, so back-to-back sends keep it high.
    task automatic send_request(logic [1:0] o, logic signed [31:0] k, logic [23:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        key <= k;
        value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_request(o, k, v);
    endtask

    // Keys are mostly drawn from small pools so that hits, misses and duplicates are common.
    function automatic logic signed [31:0] pick_key();
        case ($urandom_range(3))
            0: return 32'sh8000_0000 + $urandom_range(20);
            1: return 32'sh7FFF_FFFF - $urandom_range(20);
            2: return $signed(32'($urandom_range(40))) - 20;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [23:0] pick_value();
        if ($urandom_range(3) == 0)
            return ($urandom_range(1)) ? 24'hFFFFFF : 24'h0;
        return 24'($urandom);
    endfunction

    task automatic run_phase(int count);
        int n;
        int r;
        logic [1:0] o;
        for (n = 0; n < count; n++)
        begin
            r = $urandom_range(99);
            // Bias toward filling so the full-table cases are reached.
            if (board.keys.size() < 40)
                o = (r < 60) ? OP_INSERT : (r < 85) ? OP_DELETE : OP_AVG;
            else
                o = (r < 45) ? OP_INSERT : (r < 80) ? OP_DELETE : OP_AVG;
            if (o == OP_DELETE && board.keys.size() > 0 && $urandom_range(1))
                send_request(o, board.keys[$urandom_range(board.keys.size() - 1)],
                             24'($urandom));
            else
                send_request(o, pick_key(), pick_value());
        end
    endtask

    initial
    begin
        int i;
        board = new();
        board.clear();
        rst_n = 1'b0;
        in_valid = 1'b0;
        op = OP_INSERT;
        key = '0;
        value = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cycle_count = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty-table cases, extremes, duplicates and the unused op code.
        send_request(OP_DELETE, 32'sd5, 24'hFFFFFF);
        send_request(OP_AVG, 32'sd0, 24'h0);
        send_request(OP_INSERT, 32'sh7FFF_FFFF, 24'hFFFFFF);
        send_request(OP_INSERT, 32'sh8000_0000, 24'h0);
        send_request(OP_INSERT, 32'sd0, 24'hAAAAAA);
        send_request(OP_INSERT, -32'sd1, 24'h555555);
        send_request(OP_INSERT, 32'sd0, 24'h123456);
        send_request(OP_AVG, 32'sh5555_5555, 24'hFFFFFF);
        send_request(OP_DELETE, 32'sd7, 24'h0);
        send_request(OP_UNUSED, 32'shFFFF_FFFF, 24'hFFFFFF);
        send_request(OP_DELETE, 32'sh8000_0000, 24'h0);
        send_request(OP_DELETE, 32'sh7FFF_FFFF, 24'h0);
        send_request(OP_DELETE, 32'sd0, 24'h0);
        send_request(OP_DELETE, -32'sd1, 24'h0);
        send_request(OP_AVG, 32'sd0, 24'h0);
        // Fill to capacity, then duplicate and overflow inserts.
        for (i = 0; i < DEF_CAPACITY; i++)
            send_request(OP_INSERT, (i * 32'sd1000003) ^ 32'sh5A5A_5A5A, 24'hFFFFFF);
        send_request(OP_INSERT, 32'sh5A5A_5A5A, 24'h1);
        send_request(OP_INSERT, 32'sd12345, 24'h1);
        send_request(OP_AVG, 32'sd0, 24'h0);
        send_request(OP_UNUSED, 32'sd0, 24'h0);

        // Random phases with different idling patterns.
        send_idle_pct = 0;  recv_stall_pct = 0;  run_phase(450);
        send_idle_pct = 71; recv_stall_pct = 0;  run_phase(450);
        send_idle_pct = 0;  recv_stall_pct = 71; run_phase(450);
        send_idle_pct = 16; recv_stall_pct = 16; run_phase(450);
        in_valid <= 1'b0;

        while (board.pending() > 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (board.errors == 0 && board.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sorted_key_table_core.f
design/skt_pkg.sv
design/skt_div.sv
design/sorted_key_table_core.sv
dv/tb.sv
